// ===== design/sqc_pkg.sv =====
// Shared constants and types for the sphere/quad collision engine.
package sqc_pkg;

    localparam int COORD_WIDTH   = 20;
    localparam int NORMAL_WIDTH  = 16;
    localparam int AREA_TOL      = 131;
    localparam int QUEUE_DEPTH   = 4;
    localparam int CFG_IDX_WIDTH = 3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_WALL_NORMAL  = 3'd0,
        REG_CORNER_ONE   = 3'd1,
        REG_CORNER_TWO   = 3'd2,
        REG_CORNER_THREE = 3'd3,
        REG_CORNER_FOUR  = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

// ===== design/sqc_if.sv =====
// Valid/ready channel interfaces for sphere input and collision result.
interface sqc_in_if #(
    parameter int COORD_WIDTH = sqc_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [COORD_WIDTH-2:0] radius;

    modport source (output valid, center_x, center_y, center_z, radius, input ready);
    modport sink   (input valid, center_x, center_y, center_z, radius, output ready);
endinterface

interface sqc_out_if #(
    parameter int COORD_WIDTH = sqc_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] new_x;
    logic signed [COORD_WIDTH-1:0] new_y;
    logic signed [COORD_WIDTH-1:0] new_z;

    modport source (output valid, hit, new_x, new_y, new_z, input ready);
    modport sink   (input valid, hit, new_x, new_y, new_z, output ready);
endinterface

// ===== design/sqc_front.sv =====
// Front pipeline: plane distance, near test, projected point and push-out result.
module sqc_front #(
    parameter int COORD_WIDTH  = sqc_pkg::COORD_WIDTH,
    parameter int NORMAL_WIDTH = sqc_pkg::NORMAL_WIDTH,
    localparam int ITEM_WIDTH  = 1 + 6 * COORD_WIDTH + 3 * (COORD_WIDTH + 2)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [COORD_WIDTH-1:0]  i_center [3],
    input  logic        [COORD_WIDTH-2:0]  i_radius,
    input  logic signed [NORMAL_WIDTH-1:0] i_normal [3],
    input  logic signed [COORD_WIDTH-1:0]  i_corner_one [3],
    input  sqc_pkg::t_queue_stat           i_qstat,
    input  logic                           i_pop,
    output logic                           o_push,
    output logic        [ITEM_WIDTH-1:0]   o_item
);

    localparam int CW       = COORD_WIDTH;
    localparam int NW       = NORMAL_WIDTH;
    localparam int F        = NW - 2;
    localparam int SH       = 2 * F;
    localparam int EW       = CW + 1;
    localparam int PW       = EW + NW;
    localparam int DW       = PW + 2;
    localparam int MW       = DW + NW + 1;
    localparam int QW       = CW + 2;
    localparam int S_OFF    = 0;
    localparam int Q_OFF    = 3 * CW;
    localparam int P_OFF    = 3 * CW + 3 * QW;
    localparam int NEAR_BIT = 6 * CW + 3 * QW;

    localparam logic signed [MW-1:0] HALF   = {{(MW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
    localparam logic signed [MW-1:0] SAT_HI = {{(MW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [MW-1:0] SAT_LO = {{(MW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    logic                  w_en;
    logic [5:0]            r_v;

    logic signed [CW-1:0]  r1_s [3];
    logic signed [EW-1:0]  r1_e [3];
    logic        [CW-2:0]  r1_r;

    logic signed [CW-1:0]  r2_s [3];
    logic signed [PW-1:0]  r2_ne [3];
    logic        [CW-2:0]  r2_r;

    logic signed [CW-1:0]  r3_s [3];
    logic signed [DW-1:0]  r3_d;
    logic signed [DW-1:0]  r3_rq;

    logic signed [DW-1:0]  w_absd;
    logic signed [CW-1:0]  r4_s [3];
    logic signed [DW-1:0]  r4_d;
    logic signed [DW-1:0]  r4_m;
    logic                  r4_near;
    logic                  r4_pos;

    logic signed [CW-1:0]  r5_s [3];
    logic signed [MW-1:0]  r5_dn [3];
    logic signed [MW-1:0]  r5_pm [3];
    logic                  r5_near;
    logic                  r5_pos;

    logic [ITEM_WIDTH-1:0] n_item;
    logic [ITEM_WIDTH-1:0] r_item;

    assign w_en    = !i_qstat.full || i_pop;
    assign o_ready = w_en;
    assign o_push  = w_en && r_v[5];
    assign o_item  = r_item;
    assign w_absd  = r3_d[DW-1] ? -r3_d : r3_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_comb begin
        logic signed [MW-1:0] sfix;
        logic signed [MW-1:0] qs;
        logic signed [MW-1:0] ps;
        logic signed [MW-1:0] pr;
        n_item = '0;
        for (int k = 0; k < 3; k++) begin
            sfix = MW'(r5_s[k]) <<< SH;
            qs   = (sfix - r5_dn[k] + HALF) >>> SH;
            ps   = sfix + (r5_pos ? r5_pm[k] : -r5_pm[k]) + HALF;
            pr   = ps >>> SH;
            if (pr > SAT_HI) begin
                pr = SAT_HI;
            end else if (pr < SAT_LO) begin
                pr = SAT_LO;
            end
            n_item[S_OFF + k*CW +: CW] = r5_s[k];
            n_item[Q_OFF + k*QW +: QW] = qs[QW-1:0];
            n_item[P_OFF + k*CW +: CW] = pr[CW-1:0];
        end
        n_item[NEAR_BIT] = r5_near;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_s[k]  <= i_center[k];
                r1_e[k]  <= EW'(i_center[k]) - EW'(i_corner_one[k]);
                r2_s[k]  <= r1_s[k];
                r2_ne[k] <= PW'(i_normal[k]) * PW'(r1_e[k]);
                r3_s[k]  <= r2_s[k];
                r4_s[k]  <= r3_s[k];
                r5_s[k]  <= r4_s[k];
                r5_dn[k] <= MW'(r4_d) * MW'(i_normal[k]);
                r5_pm[k] <= MW'(r4_m) * MW'(i_normal[k]);
            end
            r1_r    <= i_radius;
            r2_r    <= r1_r;
            r3_d    <= DW'(r2_ne[0]) + DW'(r2_ne[1]) + DW'(r2_ne[2]);
            r3_rq   <= DW'({1'b0, r2_r, {F{1'b0}}});
            r4_d    <= r3_d;
            r4_near <= w_absd <= r3_rq;
            r4_m    <= r3_rq - w_absd;
            r4_pos  <= r3_d > 0;
            r5_near <= r4_near;
            r5_pos  <= r4_pos;
            r_item  <= n_item;
        end
    end

endmodule

// ===== design/sqc_fifo.sv =====
// Short first-word-fall-through queue between front and back pipelines.
module sqc_fifo #(
    parameter int WIDTH = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output sqc_pkg::t_queue_stat o_stat
);

    localparam int DEPTH = sqc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = r_count == CNT_W'(DEPTH);
    assign o_stat.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && o_stat.full |-> i_pop)
        else $error("queue write while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a write");

endmodule

// ===== design/sqc_area.sv =====
// Pipelined twice-triangle-area unit: cross product, squared norm, bit-per-stage sqrt.
module sqc_area #(
    parameter int PT_WIDTH = sqc_pkg::COORD_WIDTH + 2,
    localparam int AREA_WIDTH = 2 * (PT_WIDTH + 1) + 2
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [PT_WIDTH-1:0] i_a [3],
    input  logic signed [PT_WIDTH-1:0] i_b [3],
    input  logic signed [PT_WIDTH-1:0] i_c [3],
    output logic [AREA_WIDTH-1:0]      o_area
);

    localparam int QW  = PT_WIDTH;
    localparam int UW  = QW + 1;
    localparam int XW  = 2 * UW + 1;
    localparam int HW  = (XW + 1) / 2;
    localparam int GW  = XW - HW;
    localparam int SQW = 2 * XW;
    localparam int SW  = SQW + 2;
    localparam int RW  = SW / 2;

    logic signed [UW-1:0]   r_u [3];
    logic signed [UW-1:0]   r_w [3];
    logic signed [2*UW-1:0] r_m [6];
    logic        [XW-1:0]   r_x [3];
    logic [2*GW-1:0]        r_hh [3];
    logic [GW+HW-1:0]       r_hl [3];
    logic [2*HW-1:0]        r_ll [3];
    logic [SQW-1:0]         r_sq [3];
    logic [SW-1:0]          r_rem [RW+1];
    logic [RW-1:0]          r_root [RW+1];
    logic signed [XW-1:0]   w_cr [3];
    logic [SW-1:0]          w_trial [RW];

    always_comb begin
        w_cr[0] = XW'(r_m[0]) - XW'(r_m[1]);
        w_cr[1] = XW'(r_m[2]) - XW'(r_m[3]);
        w_cr[2] = XW'(r_m[4]) - XW'(r_m[5]);
    end

    always_comb begin
        for (int g = 0; g < RW; g++) begin
            w_trial[g] = (SW'(r_root[g]) << (RW - g)) | (SW'(1) << (2 * (RW - 1 - g)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_u[k] <= UW'(i_b[k]) - UW'(i_a[k]);
                r_w[k] <= UW'(i_c[k]) - UW'(i_a[k]);
            end
            r_m[0] <= (2*UW)'(r_u[1]) * (2*UW)'(r_w[2]);
            r_m[1] <= (2*UW)'(r_u[2]) * (2*UW)'(r_w[1]);
            r_m[2] <= (2*UW)'(r_u[2]) * (2*UW)'(r_w[0]);
            r_m[3] <= (2*UW)'(r_u[0]) * (2*UW)'(r_w[2]);
            r_m[4] <= (2*UW)'(r_u[0]) * (2*UW)'(r_w[1]);
            r_m[5] <= (2*UW)'(r_u[1]) * (2*UW)'(r_w[0]);
            for (int j = 0; j < 3; j++) begin
                r_x[j]  <= w_cr[j][XW-1] ? XW'(-w_cr[j]) : XW'(w_cr[j]);
                r_hh[j] <= (2*GW)'(r_x[j][XW-1:HW]) * (2*GW)'(r_x[j][XW-1:HW]);
                r_hl[j] <= (GW+HW)'(r_x[j][XW-1:HW]) * (GW+HW)'(r_x[j][HW-1:0]);
                r_ll[j] <= (2*HW)'(r_x[j][HW-1:0]) * (2*HW)'(r_x[j][HW-1:0]);
                r_sq[j] <= (SQW'(r_hh[j]) << (2*HW)) + (SQW'(r_hl[j]) << (HW+1))
                         + SQW'(r_ll[j]);
            end
            r_rem[0]  <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_root[0] <= '0;
            for (int g = 0; g < RW; g++) begin
                if (r_rem[g] >= w_trial[g]) begin
                    r_rem[g+1]  <= r_rem[g] - w_trial[g];
                    r_root[g+1] <= r_root[g] | (RW'(1) << (RW - 1 - g));
                end else begin
                    r_rem[g+1]  <= r_rem[g];
                    r_root[g+1] <= r_root[g];
                end
            end
        end
    end

    assign o_area = r_root[RW];

endmodule

// ===== design/sqc_back.sv =====
// Back pipeline: quad containment by area sums and result register.
module sqc_back #(
    parameter int COORD_WIDTH = sqc_pkg::COORD_WIDTH,
    localparam int ITEM_WIDTH = 1 + 6 * COORD_WIDTH + 3 * (COORD_WIDTH + 2)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sqc_pkg::t_queue_stat          i_qstat,
    output logic                          o_pop,
    input  logic [ITEM_WIDTH-1:0]         i_item,
    input  logic signed [COORD_WIDTH-1:0] i_corner [4][3],
    sqc_out_if.source                     o_out
);

    localparam int CW       = COORD_WIDTH;
    localparam int QW       = CW + 2;
    localparam int AW       = 2 * (QW + 1) + 2;
    localparam int LAT      = 6 + AW;
    localparam int SUMW     = AW + 2;
    localparam int PAYW     = 1 + 6 * CW;
    localparam int S_OFF    = 0;
    localparam int Q_OFF    = 3 * CW;
    localparam int P_OFF    = 3 * CW + 3 * QW;
    localparam int NEAR_BIT = 6 * CW + 3 * QW;

    logic                 w_en;
    logic signed [QW-1:0] w_p [4][3];
    logic signed [QW-1:0] w_q [3];
    logic [AW-1:0]        w_area [7];
    logic [PAYW-1:0]      w_pay;
    logic [PAYW-1:0]      r_pay [LAT];
    logic [LAT-1:0]       r_dv;
    logic                 w_in_one;
    logic                 w_in_two;
    logic                 w_hit;
    logic                 r_ovalid;
    logic                 r_hit;
    logic signed [CW-1:0] r_new [3];

    assign w_en  = !r_ovalid || o_out.ready;
    assign o_pop = w_en && !i_qstat.empty;

    always_comb begin
        w_pay = '0;
        for (int k = 0; k < 3; k++) begin
            w_q[k] = i_item[Q_OFF + k*QW +: QW];
            w_pay[k*CW +: CW]        = i_item[S_OFF + k*CW +: CW];
            w_pay[3*CW + k*CW +: CW] = i_item[P_OFF + k*CW +: CW];
            for (int j = 0; j < 4; j++) begin
                w_p[j][k] = QW'(i_corner[j][k]);
            end
        end
        w_pay[PAYW-1] = i_item[NEAR_BIT];
    end

    sqc_area #(.PT_WIDTH(QW)) u_area_whole_one (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_p[0]), .i_b(w_p[1]), .i_c(w_p[2]),
        .o_area(w_area[0])
    );
    sqc_area #(.PT_WIDTH(QW)) u_area_whole_two (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_p[0]), .i_b(w_p[2]), .i_c(w_p[3]),
        .o_area(w_area[1])
    );
    sqc_area #(.PT_WIDTH(QW)) u_area_p12 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_p[0]), .i_b(w_p[1]), .i_c(w_q),
        .o_area(w_area[2])
    );
    sqc_area #(.PT_WIDTH(QW)) u_area_p23 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_p[1]), .i_b(w_p[2]), .i_c(w_q),
        .o_area(w_area[3])
    );
    sqc_area #(.PT_WIDTH(QW)) u_area_p13 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_p[0]), .i_b(w_p[2]), .i_c(w_q),
        .o_area(w_area[4])
    );
    sqc_area #(.PT_WIDTH(QW)) u_area_p34 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_p[2]), .i_b(w_p[3]), .i_c(w_q),
        .o_area(w_area[5])
    );
    sqc_area #(.PT_WIDTH(QW)) u_area_p14 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_p[0]), .i_b(w_p[3]), .i_c(w_q),
        .o_area(w_area[6])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (w_en) begin
            r_dv <= {r_dv[LAT-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pay[0] <= w_pay;
            for (int g = 1; g < LAT; g++) begin
                r_pay[g] <= r_pay[g-1];
            end
        end
    end

    always_comb begin
        logic [SUMW-1:0] whole_one;
        logic [SUMW-1:0] whole_two;
        logic [SUMW-1:0] sum_one;
        logic [SUMW-1:0] sum_two;
        logic [SUMW-1:0] diff_one;
        logic [SUMW-1:0] diff_two;
        whole_one = SUMW'(w_area[0]);
        whole_two = SUMW'(w_area[1]);
        sum_one   = SUMW'(w_area[2]) + SUMW'(w_area[3]) + SUMW'(w_area[4]);
        sum_two   = SUMW'(w_area[4]) + SUMW'(w_area[5]) + SUMW'(w_area[6]);
        diff_one  = (whole_one > sum_one) ? whole_one - sum_one : sum_one - whole_one;
        diff_two  = (whole_two > sum_two) ? whole_two - sum_two : sum_two - whole_two;
        w_in_one  = diff_one < SUMW'(sqc_pkg::AREA_TOL);
        w_in_two  = diff_two < SUMW'(sqc_pkg::AREA_TOL);
        w_hit     = r_pay[LAT-1][PAYW-1] && (w_in_one || w_in_two);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= r_dv[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= w_hit;
            for (int k = 0; k < 3; k++) begin
                r_new[k] <= w_hit ? r_pay[LAT-1][3*CW + k*CW +: CW]
                                  : r_pay[LAT-1][k*CW +: CW];
            end
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.hit   = r_hit;
    assign o_out.new_x = r_new[0];
    assign o_out.new_y = r_new[1];
    assign o_out.new_z = r_new[2];

endmodule

// ===== design/sphere_quad_collision_top.sv =====
// Top level of the sphere versus quad wall collision engine.
//
//  channel   | dir | handshake      | transaction
//  ----------+-----+----------------+---------------------------------------
//  i_in      | in  | valid/ready    | center_x/y/z, radius (one sphere)
//  o_out     | out | valid/ready    | hit, new_x/y/z (one result per sphere)
//  i_cfg_*   | in  | write enable   | i_cfg_idx selects normal or corner 1..4
//
//  One sphere per cycle sustained while o_out is ready. The seven area
//  units use bit-per-stage square-root pipelines. Front and back stall
//  independently, decoupled by a 4-entry queue. Synchronous active-low
//  reset clears control and the wall registers. The user must write
//  configuration only while the engine is idle; the block does not enforce it.
module sphere_quad_collision_top #(
    parameter int COORD_WIDTH  = sqc_pkg::COORD_WIDTH,
    parameter int NORMAL_WIDTH = sqc_pkg::NORMAL_WIDTH,
    localparam int CFG_WIDTH   = (COORD_WIDTH > NORMAL_WIDTH) ? 3 * COORD_WIDTH
                                                             : 3 * NORMAL_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sqc_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [CFG_WIDTH-1:0]              i_cfg_wdata,
    sqc_in_if.sink                            i_in,
    sqc_out_if.source                         o_out
);

    localparam int CW         = COORD_WIDTH;
    localparam int NW         = NORMAL_WIDTH;
    localparam int ITEM_WIDTH = 1 + 6 * CW + 3 * (CW + 2);

    logic [3*NW-1:0]        r_normal;
    logic [3*CW-1:0]        r_corner [4];
    logic signed [NW-1:0]   w_normal [3];
    logic signed [CW-1:0]   w_corner [4][3];
    logic signed [CW-1:0]   w_center [3];
    logic                   w_ready;
    logic                   w_push;
    logic                   w_pop;
    logic [ITEM_WIDTH-1:0]  w_front_item;
    logic [ITEM_WIDTH-1:0]  w_back_item;
    sqc_pkg::t_queue_stat   w_qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal <= '0;
            for (int j = 0; j < 4; j++) begin
                r_corner[j] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sqc_pkg::REG_WALL_NORMAL:  r_normal    <= i_cfg_wdata[3*NW-1:0];
                sqc_pkg::REG_CORNER_ONE:   r_corner[0] <= i_cfg_wdata[3*CW-1:0];
                sqc_pkg::REG_CORNER_TWO:   r_corner[1] <= i_cfg_wdata[3*CW-1:0];
                sqc_pkg::REG_CORNER_THREE: r_corner[2] <= i_cfg_wdata[3*CW-1:0];
                sqc_pkg::REG_CORNER_FOUR:  r_corner[3] <= i_cfg_wdata[3*CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_normal[k] = r_normal[k*NW +: NW];
            for (int j = 0; j < 4; j++) begin
                w_corner[j][k] = r_corner[j][k*CW +: CW];
            end
        end
    end

    assign w_center[0] = i_in.center_x;
    assign w_center[1] = i_in.center_y;
    assign w_center[2] = i_in.center_z;
    assign i_in.ready  = w_ready;

    sqc_front #(
        .COORD_WIDTH (CW),
        .NORMAL_WIDTH(NW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (w_ready),
        .i_center    (w_center),
        .i_radius    (i_in.radius),
        .i_normal    (w_normal),
        .i_corner_one(w_corner[0]),
        .i_qstat     (w_qstat),
        .i_pop       (w_pop),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    sqc_fifo #(
        .WIDTH(ITEM_WIDTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_front_item),
        .i_pop  (w_pop),
        .o_data (w_back_item),
        .o_stat (w_qstat)
    );

    sqc_back #(
        .COORD_WIDTH(CW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .i_item  (w_back_item),
        .i_corner(w_corner),
        .o_out   (o_out)
    );

endmodule
